// ===== rtl/max_black_border_square_top_assert.svh =====
// Assertion macros for the bordered square finder
`ifndef MAX_BLACK_BORDER_SQUARE_TOP_ASSERT_SVH
`define MAX_BLACK_BORDER_SQUARE_TOP_ASSERT_SVH

// check a property on every clock edge outside reset
`define MBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that an implication holds in the next cycle
`define MBS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/mbbs_pkg.sv =====
`timescale 1ns / 1ps
package mbbs_pkg;
    localparam int MAX_SIDE_DEF = 64;
    localparam logic [6:0] MATRIX_SIZE_RESET = 7'd64;
endpackage

// ===== rtl/max_black_border_square_top.sv =====
`timescale 1ns / 1ps
`include "max_black_border_square_top_assert.svh"
// Largest black-bordered square finder.
// Configuration: matrix_size_we/matrix_size_wdata set side N (0 acts as 1,
// above MAX_SIDE acts as MAX_SIDE); a write restarts the pixel load count.
// Input: one pixel per transfer (start high, busy low), raster order,
// pixel_white = 1 means white. Pixels load one per cycle.
// After the N*N-th pixel busy rises. A run pass walks the image backwards,
// in three states per pixel (two store reads, one write).
// The search then tries sides N..1 and positions in raster order, three
// store reads per candidate through the single read port, in four states
// each (ST_STL, ST_STR, ST_SBL, ST_SCHK), one candidate at a time.
// The result is shown for one cycle with done high: found, square_size,
// top_row, left_col (all zero if no square). busy is already low in that
// cycle, so the next pixel may be taken at the same edge.
// The receiver cannot stall; done is not held, but result registers are.
// Reset clears control state and sets N to 64; stores are not cleared.
module max_black_border_square_top
    import mbbs_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       matrix_size_we,
    input  logic [6:0] matrix_size_wdata,
    input  logic       start,
    input  logic       pixel_white,
    output logic       busy,
    output logic       done,
    output logic       found,
    output logic [6:0] square_size,
    output logic [5:0] top_row,
    output logic [5:0] left_col
);
    localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_RRD  = 4'd1;
    localparam logic [3:0] ST_RWR  = 4'd2;
    localparam logic [3:0] ST_STL  = 4'd3;
    localparam logic [3:0] ST_STR  = 4'd4;
    localparam logic [3:0] ST_SBL  = 4'd5;
    localparam logic [3:0] ST_SCHK = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;
    localparam logic [3:0] ST_RWT  = 4'd8;

    logic [6:0]      size_reg;
    logic [SW-1:0]   n;
    logic [3:0]      state_reg;
    logic [AW:0]     load_cnt_reg;
    logic [CW-1:0]   r_reg, c_reg;
    logic [SW-1:0]   k_reg;
    logic [SW-1:0]   right_hold_reg;
    logic            pix_hold_reg;
    logic            ok_reg;

    logic            pix_mem [DEPTH];
    logic [2*SW-1:0] run_mem [DEPTH];
    logic            pix_q;
    logic [2*SW-1:0] run_q;

    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            run_we;
    logic [2*SW-1:0] run_wd;
    logic            pix_we;

    logic            done_reg, found_reg;
    logic [6:0]      size_out_reg;
    logic [5:0]      row_out_reg, col_out_reg;

    always_comb
    begin
        if (size_reg == 7'd0)
            n = SW'(1);
        else if (32'(size_reg) > MAX_SIDE)
            n = SW'(MAX_SIDE);
        else
            n = SW'(size_reg);
    end

    logic [AW:0] total;
    assign total = (AW+1)'(32'(n) * 32'(n));

    function automatic logic [AW-1:0] lin(input logic [CW:0] r, input logic [CW:0] c,
                                          input logic [SW-1:0] nn);
        lin = AW'(32'(r) * 32'(nn) + 32'(c));
    endfunction

    logic [CW:0] r_ext, c_ext, km1;
    logic [CW:0] r_nx, c_nx;
    assign r_ext = (CW+1)'(r_reg);
    assign c_ext = (CW+1)'(c_reg);
    assign km1   = (CW+1)'(k_reg - SW'(1));
    assign r_nx  = r_ext + (CW+1)'(1);
    assign c_nx  = c_ext + (CW+1)'(1);

    always_comb
    begin
        rd_addr = lin(r_ext, c_ext, n);
        unique case (state_reg)
            ST_RRD:  rd_addr = (c_nx < (CW+1)'(n)) ? lin(r_ext, c_nx, n)
                                                    : lin(r_ext, c_ext, n);
            ST_RWT:  rd_addr = (r_nx < (CW+1)'(n)) ? lin(r_nx, c_ext, n)
                                                    : lin(r_ext, c_ext, n);
            ST_STR:  rd_addr = lin(r_ext, c_ext + km1, n);
            ST_SBL:  rd_addr = lin(r_ext + km1, c_ext, n);
            default: rd_addr = lin(r_ext, c_ext, n);
        endcase
    end

    assign pix_we = (state_reg == ST_LOAD) && start;
    assign wr_addr = (state_reg == ST_LOAD) ? AW'(load_cnt_reg) : lin(r_ext, c_ext, n);

    logic [SW-1:0] rt_new, dn_new;
    always_comb
    begin
        rt_new = SW'(1);
        dn_new = SW'(1);
        if (c_nx < (CW+1)'(n))
            rt_new = right_hold_reg + SW'(1);
        if (r_nx < (CW+1)'(n))
            dn_new = run_q[SW-1:0] + SW'(1);
        if (pix_hold_reg)
        begin
            rt_new = '0;
            dn_new = '0;
        end
    end
    assign run_we = (state_reg == ST_RWR);
    assign run_wd = {rt_new, dn_new};

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[wr_addr] <= pixel_white;
        if (run_we)
            run_mem[wr_addr] <= run_wd;
        pix_q <= pix_mem[lin(r_ext, c_ext, n)];
        run_q <= run_mem[rd_addr];
    end

    logic [SW-1:0] run_r, run_d;
    assign run_r = run_q[2*SW-1:SW];
    assign run_d = run_q[SW-1:0];

    logic last_c, last_r;
    assign last_c = (c_ext + (CW+1)'(k_reg)) >= (CW+1)'(n);
    assign last_r = (r_ext + (CW+1)'(k_reg)) >= (CW+1)'(n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= MATRIX_SIZE_RESET;
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            ok_reg       <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            size_out_reg <= '0;
            row_out_reg  <= '0;
            col_out_reg  <= '0;
            right_hold_reg <= '0;
            pix_hold_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (matrix_size_we)
            begin
                size_reg     <= matrix_size_wdata;
                load_cnt_reg <= '0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (start && !matrix_size_we)
                    begin
                        if (load_cnt_reg + (AW+1)'(1) >= total)
                        begin
                            load_cnt_reg <= '0;
                            r_reg <= CW'(n - SW'(1));
                            c_reg <= CW'(n - SW'(1));
                            right_hold_reg <= '0;
                            state_reg <= ST_RRD;
                        end
                        else
                            load_cnt_reg <= load_cnt_reg + (AW+1)'(1);
                    end
                end
                ST_RRD:
                    state_reg <= ST_RWT;
                ST_RWT:
                begin
                    right_hold_reg <= run_q[2*SW-1:SW];
                    pix_hold_reg   <= pix_q;
                    state_reg <= ST_RWR;
                end
                ST_RWR:
                begin
                    right_hold_reg <= rt_new;
                    if (c_reg != '0)
                    begin
                        c_reg <= c_reg - CW'(1);
                        state_reg <= ST_RRD;
                    end
                    else if (r_reg != '0)
                    begin
                        r_reg <= r_reg - CW'(1);
                        c_reg <= CW'(n - SW'(1));
                        state_reg <= ST_RRD;
                    end
                    else
                    begin
                        k_reg <= n;
                        state_reg <= ST_STL;
                    end
                end
                ST_STL:
                    state_reg <= ST_STR;
                ST_STR:
                begin
                    ok_reg <= (run_r >= k_reg) && (run_d >= k_reg);
                    state_reg <= ST_SBL;
                end
                ST_SBL:
                begin
                    ok_reg <= ok_reg && (run_d >= k_reg);
                    state_reg <= ST_SCHK;
                end
                ST_SCHK:
                begin
                    if (ok_reg && (run_r >= k_reg))
                    begin
                        found_reg    <= 1'b1;
                        size_out_reg <= 7'(k_reg);
                        row_out_reg  <= 6'(r_reg);
                        col_out_reg  <= 6'(c_reg);
                        state_reg    <= ST_OUT;
                    end
                    else if (!last_c)
                    begin
                        c_reg <= c_reg + CW'(1);
                        state_reg <= ST_STL;
                    end
                    else if (!last_r)
                    begin
                        c_reg <= '0;
                        r_reg <= r_reg + CW'(1);
                        state_reg <= ST_STL;
                    end
                    else if (k_reg > SW'(1))
                    begin
                        k_reg <= k_reg - SW'(1);
                        r_reg <= '0;
                        c_reg <= '0;
                        state_reg <= ST_STL;
                    end
                    else
                    begin
                        found_reg    <= 1'b0;
                        size_out_reg <= '0;
                        row_out_reg  <= '0;
                        col_out_reg  <= '0;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_LOAD;
                end
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

    assign busy        = (state_reg != ST_LOAD);
    assign done        = done_reg;
    assign found       = found_reg;
    assign square_size = size_out_reg;
    assign top_row     = row_out_reg;
    assign left_col    = col_out_reg;

    `MBS_ASSERT(a_done_idle, !(done && busy), "result while busy")
    `MBS_ASSERT(a_found_size, !(done && found && square_size == 7'd0), "found with size zero")
    `MBS_ASSERT_NEXT(a_out_done, state_reg == ST_OUT, done, "result not shown")
    `MBS_ASSERT(a_nofind_zero, !(done && !found && |{square_size, top_row, left_col}), "bad empty")
endmodule
